/* rtl/attribute_table_get_set_engine_macros.svh */
// Assertion macros for the attribute table engine
`ifndef ATTRIBUTE_TABLE_GET_SET_ENGINE_MACROS_SVH
`define ATTRIBUTE_TABLE_GET_SET_ENGINE_MACROS_SVH
`ifndef ASSERT_OFF
`define ATGS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ATGS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ATGS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define ATGS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* rtl/atgs_pkg.sv */
// Package: types, constants and helpers for the attribute table engine
package atgs_pkg;
    localparam int TableDepth = 32;
    localparam int SlotW = $clog2(TableDepth);
    localparam int CntW = SlotW + 1;
    localparam int MaxValueBytes = 4;

    typedef enum logic [2:0] {
        OP_GET = 3'd0, OP_SET = 3'd1, OP_GET_ALL = 3'd2, OP_DEFINE = 3'd3,
        OP_RSV4 = 3'd4, OP_RSV5 = 3'd5, OP_RSV6 = 3'd6, OP_RSV7 = 3'd7
    } t_opcode;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_UNSUPPORTED = 3'd1;
    localparam logic [2:0] ST_INVALID_ATTR = 3'd2;
    localparam logic [2:0] ST_NOT_SETTABLE = 3'd3;
    localparam logic [2:0] ST_INVALID_PARAM = 3'd4;

    localparam logic [1:0] VT_U8 = 2'd0;
    localparam logic [1:0] VT_U16 = 2'd1;
    localparam logic [1:0] VT_S16 = 2'd2;
    localparam logic [1:0] VT_NONE = 2'd3;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [7:0]  cls_num;
        logic [7:0]  inst_num;
        logic [7:0]  attr_num;
        logic [31:0] data_word;
        logic [7:0]  byte_count;
        logic [4:0]  slot;
        logic        read_only;
        logic [1:0]  value_type;
        logic signed [31:0] min_limit;
        logic signed [31:0] max_limit;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] read_value;
        logic [2:0]  read_bytes;
        logic        last_result;
    } t_rsp;

    // one table entry as it travels down the cell chain
    typedef struct packed {
        logic [23:0] path;
        logic [31:0] value;
        logic [2:0]  size;
        logic        ro;
        logic [1:0]  vtype;
        logic [31:0] low;
        logic [31:0] high;
    } t_entry;

    // control from sequencer to each cell
    typedef struct packed {
        logic shift;   // rotate the chain one place
        logic load;    // tail cell takes the write-back entry
    } t_cell_ctl;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_WRAP, S_RESULT
    } t_state;

    function automatic logic [31:0] size_mask(input logic [2:0] bytes);
        logic [31:0] m;
        begin
            unique case (bytes)
                3'd0: m = 32'h0000_0000;
                3'd1: m = 32'h0000_00FF;
                3'd2: m = 32'h0000_FFFF;
                3'd3: m = 32'h00FF_FFFF;
                default: m = 32'hFFFF_FFFF;
            endcase
            return m;
        end
    endfunction
endpackage

/* rtl/attribute_table_get_set_engine.sv */
// Top level: attribute table get/set engine built on a rotating cell chain
//
//  channel  | handshake              | payload
//  request  | i_start / o_busy       | i_req (t_req)
//  config   | i_cfg_we               | i_cfg_data (entries_in_use)
//  result   | o_valid (one strobe)   | o_rsp (t_rsp)
//
// Each request rotates the 32-cell chain one full turn: the slots reach the
// head cell in order, so the length of a request is set by the length of
// the chain. Results of get-all stream out as the matching cells pass the
// head. Reset is synchronous active low and clears control and modified
// bits; entries hold until defined. The receiver cannot stall: each result
// shows for one cycle with o_valid.
module attribute_table_get_set_engine
    import atgs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    output logic       o_busy,
    input  t_req       i_req,
    input  logic       i_cfg_we,
    input  logic [5:0] i_cfg_data,
    output logic       o_valid,
    output t_rsp       o_rsp
);
    `include "attribute_table_get_set_engine_macros.svh"

    t_state r_state, n_state;
    t_req   r_req;
    logic [5:0] r_in_use;
    logic [CntW-1:0] r_idx;       // slot now at the head cell
    logic [CntW-1:0] r_limit;     // number of slots searched
    logic [CntW-1:0] r_hits;      // get-all matches emitted
    logic r_found;
    logic [TableDepth-1:0] r_modified;
    t_rsp r_rsp;
    logic r_valid;
    logic r_fin_pend;             // final result still owed
    t_rsp r_fin;

    t_cell_ctl w_ctl;
    t_entry w_cell [TableDepth];
    t_entry w_head;
    t_entry w_load;

    // chain: cell 0 is the head; cell k feeds cell k-1; head wraps to tail
    assign w_head = w_cell[0];
    genvar g;
    generate
        for (g = 0; g < TableDepth; g++) begin : g_cell
            t_cell_ctl w_c;
            always_comb begin
                w_c.shift = w_ctl.shift;
                w_c.load  = w_ctl.load && (g == TableDepth - 1);
            end
            atgs_cell u_cell (
                .i_clk  (i_clk),
                .i_ctl  (w_c),
                .i_prev (w_cell[(g + 1) % TableDepth]),
                .i_load (w_load),
                .o_entry(w_cell[g])
            );
        end
    endgenerate

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use <= '0;
        end else if (i_cfg_we) begin
            r_in_use <= i_cfg_data;
        end
    end

    // head-cell compare and set checks
    logic w_in_range, w_match_full, w_match_ci;
    logic [23:0] w_path;
    logic signed [31:0] w_v;
    logic w_range_ok;
    always_comb begin
        w_path = {r_req.cls_num, r_req.inst_num, r_req.attr_num};
        w_in_range = (r_idx < r_limit);
        w_match_full = w_in_range && (w_head.path == w_path);
        w_match_ci = w_in_range && (w_head.path[23:8] == w_path[23:8]);
        unique case (w_head.vtype)
            VT_U8:  w_v = {24'd0, r_req.data_word[7:0]};
            VT_U16: w_v = {16'd0, r_req.data_word[15:0]};
            default: w_v = {{16{r_req.data_word[15]}}, r_req.data_word[15:0]};
        endcase
        w_range_ok = (w_head.vtype == VT_NONE) ||
                     (!(w_v < $signed(w_head.low)) && !(w_v > $signed(w_head.high)));
    end

    logic w_define_ok;
    assign w_define_ok = (r_req.byte_count != 8'd0) &&
        (r_req.byte_count <= 8'(MaxValueBytes > 4 ? 4 : MaxValueBytes));

    // result strobe and the final word given in the wrap cycle
    logic w_ga_hit;
    logic w_emit;
    t_rsp w_final;
    always_comb begin
        w_ga_hit = w_match_ci && (r_hits < CntW'(TableDepth));
        w_emit = (r_state == S_WRAP) ||
                 ((r_state == S_SCAN) && (t_opcode'(r_req.opcode) == OP_GET_ALL) &&
                  w_ga_hit && r_fin_pend);
        w_final = '{status: ST_OK, read_value: '0, read_bytes: '0, last_result: 1'b1};
        unique case (t_opcode'(r_req.opcode))
            OP_GET, OP_SET: begin
                if (r_found) w_final = r_fin;
                else w_final.status = ST_INVALID_ATTR;
            end
            OP_GET_ALL: begin
                if (r_fin_pend) begin
                    w_final = r_fin;
                    w_final.last_result = 1'b1;
                end else begin
                    w_final.status = ST_INVALID_ATTR;
                end
            end
            OP_DEFINE: begin
                if (!w_define_ok) w_final.status = ST_INVALID_PARAM;
            end
            default: w_final.status = ST_UNSUPPORTED;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_start) n_state = S_SCAN;
            S_SCAN:   if (r_idx == CntW'(TableDepth - 1)) n_state = S_WRAP;
            S_WRAP:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // chain control outputs
    always_comb begin
        w_ctl.shift = (r_state == S_SCAN);
        w_ctl.load  = 1'b0;
        w_load = w_head;
        if (r_state == S_SCAN) begin
            unique case (t_opcode'(r_req.opcode))
                OP_SET: begin
                    if (w_match_full && !r_found && !w_head.ro &&
                        (r_req.byte_count == {5'd0, w_head.size}) && w_range_ok) begin
                        w_ctl.load = 1'b1;
                        w_load.value = r_req.data_word & size_mask(w_head.size);
                    end
                end
                OP_DEFINE: begin
                    if (w_define_ok && (r_idx[SlotW-1:0] == r_req.slot)) begin
                        w_ctl.load = 1'b1;
                        w_load.path  = w_path;
                        w_load.size  = r_req.byte_count[2:0];
                        w_load.value = r_req.data_word & size_mask(r_req.byte_count[2:0]);
                        w_load.ro    = r_req.read_only;
                        w_load.vtype = r_req.value_type;
                        w_load.low   = r_req.min_limit;
                        w_load.high  = r_req.max_limit;
                    end
                end
                default: ;
            endcase
        end
    end

    // sequencer datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_modified <= '0;
            r_fin_pend <= 1'b0;
            r_idx <= '0;
            r_hits <= '0;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= w_emit;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_req <= i_req;
                        r_idx <= '0;
                        r_hits <= '0;
                        r_found <= 1'b0;
                        r_limit <= (r_in_use > 6'(TableDepth)) ? CntW'(TableDepth)
                                                               : CntW'(r_in_use);
                    end
                end
                S_SCAN: begin
                    r_idx <= r_idx + CntW'(1);
                    unique case (t_opcode'(r_req.opcode))
                        OP_GET, OP_SET: begin
                            if (w_match_full && !r_found) begin
                                r_found <= 1'b1;
                                if (r_req.opcode == OP_GET) begin
                                    r_fin <= '{status: ST_OK,
                                        read_value: w_head.value & size_mask(w_head.size),
                                        read_bytes: w_head.size, last_result: 1'b1};
                                end else if (w_head.ro) begin
                                    r_fin <= '{status: ST_NOT_SETTABLE, read_value: '0,
                                               read_bytes: '0, last_result: 1'b1};
                                end else if ((r_req.byte_count != {5'd0, w_head.size})
                                             || !w_range_ok) begin
                                    r_fin <= '{status: ST_INVALID_PARAM, read_value: '0,
                                               read_bytes: '0, last_result: 1'b1};
                                end else begin
                                    r_fin <= '{status: ST_OK, read_value: '0,
                                               read_bytes: '0, last_result: 1'b1};
                                    r_modified[r_idx[SlotW-1:0]] <= 1'b1;
                                end
                            end
                        end
                        OP_GET_ALL: begin
                            if (w_ga_hit) begin
                                // emit held result, hold this one as pending last
                                if (r_fin_pend) begin
                                    r_rsp <= r_fin;
                                end
                                r_fin_pend <= 1'b1;
                                r_fin <= '{status: ST_OK,
                                    read_value: w_head.value & size_mask(w_head.size),
                                    read_bytes: w_head.size, last_result: 1'b0};
                                r_hits <= r_hits + CntW'(1);
                            end
                        end
                        OP_DEFINE: begin
                            if (w_define_ok && (r_idx[SlotW-1:0] == r_req.slot)) begin
                                r_modified[r_idx[SlotW-1:0]] <= 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
                S_WRAP: begin
                    r_fin_pend <= 1'b0;
                    r_rsp <= w_final;
                end
                default: ;
            endcase
        end
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

    `ATGS_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, i_start && !o_busy, o_busy,
        "accepted request did not raise busy")
    `ATGS_ASSERT_IMPL(a_valid_idle, i_clk, i_rst_n, o_valid && o_rsp.last_result,
        r_state == S_IDLE, "final word outside idle")
    `ATGS_ASSERT_IMPL(a_wrap_idx, i_clk, i_rst_n, r_state == S_WRAP,
        r_idx == CntW'(TableDepth), "chain not fully rotated")
    `ATGS_ASSERT_IMPL(a_hit_once, i_clk, i_rst_n, r_state == S_SCAN,
        r_hits <= CntW'(TableDepth), "too many matches emitted")
endmodule

/* rtl/atgs_cell.sv */
// One table cell: holds one entry and hands it to its neighbor on shift
module atgs_cell
    import atgs_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  t_entry    i_prev,
    input  t_entry    i_load,
    output t_entry    o_entry
);
    t_entry r_entry;

    // entry storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_entry <= i_ctl.load ? i_load : i_prev;
        end
    end

    assign o_entry = r_entry;
endmodule
